// ===== hw/rtl/qap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized average pooling accumulator package
// Item types, configuration codes and fixed widths shared by the block.
// ----------------------------------------------------------------------------
package qap_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int CH_W       = 8;
  localparam int CH_CODES   = 1 << CH_W;
  localparam int SUM_W      = 32;
  localparam int RECIP_W    = 17;
  localparam int SHIFT_W    = 6;
  localparam int MAG_W      = 48;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Saturation limits of the running sum
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Magnitude clamp ahead of a left shift, and output limits
  localparam logic [MAG_W-1:0] MAG_CLAMP = MAG_W'(1) << 20;
  localparam logic [MAG_W-1:0] OUT8_MAX  = MAG_W'(127);
  localparam logic [MAG_W-1:0] OUT16_MAX = MAG_W'(32767);

  // Reset values of the configuration registers
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(65536);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CfgAreaRecip = 2'd0,
    CfgExpShift  = 2'd1,
    CfgOutMode   = 2'd2
  } qap_cfg_idx_e;

  // Input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            channel;
    logic                       last_position;
    logic                       last_channel;
  } qap_in_t;

  // Result item
  typedef struct packed {
    logic signed [OUT_W-1:0] pooled_value;
    logic [CH_W-1:0]         out_channel;
    logic                    last_of_pixel;
  } qap_out_t;

  // Finished window sum handed to the scaler
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CH_W-1:0]         channel;
    logic                    last_of_pixel;
  } qap_sum_t;

  // Item tags carried along the scaler pipeline
  typedef struct packed {
    logic            neg;
    logic [CH_W-1:0] channel;
    logic            last_of_pixel;
  } qap_meta_t;

  // Scaling controls from the configuration registers
  typedef struct packed {
    logic [RECIP_W-1:0]        area_reciprocal;
    logic signed [SHIFT_W-1:0] exponent_shift;
    logic                      output_mode;
  } qap_scale_cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/quantized_avg_pool_accumulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized average pooling accumulator
// Per-channel saturating window sums in a memory, scaled, rounded and
// saturated on the window's last position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o / in_item_i. One item is a signed
//   sample with its channel index and position/channel flags. Channel indexes
//   fold modulo CHANNELS. Items with last_position set produce one result on
//   out_valid_o / out_stall_i / out_item_o; other items produce none.
//   Throughput is one item per cycle while in_stall_o is low: the sum memory is
//   read when an item is taken and written back when the item leaves stage 1,
//   and a forwarding register covers a back-to-back item on the same channel.
//   A result reaches the output register through the read, accumulate,
//   magnitude, multiply, shift and round/saturate stages.
//   Reset: the configuration returns to reciprocal one, shift zero, 8-bit
//   output, and a clearing pass zeroes the sum memory one entry per cycle,
//   with in_stall_o high. Configuration writes (cfg_we_i, cfg_idx_i,
//   cfg_wdata_i) are to be made only while idle; the block itself does not enforce this.
//   Stall: when the receiver stalls with the output register full, results
//   pile up in the pipeline stages; items that produce no result still flow,
//   and in_stall_o rises only once a result item cannot move on.
// ----------------------------------------------------------------------------
module quantized_avg_pool_accumulator_unit import qap_pkg::*; #(
  parameter int CHANNELS = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire qap_in_t               in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output qap_out_t                   out_item_o
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  // Fold each channel code onto a memory entry (code modulo CHANNELS)
  function automatic logic [CH_CODES-1:0][IdxW-1:0] build_chan_map();
    logic [CH_CODES-1:0][IdxW-1:0] map;
    int unsigned                   r;
    r = 0;
    for (int i = 0; i < CH_CODES; i++) begin
      map[i] = IdxW'(r);
      r = (r + 1 == CHANNELS) ? 0 : r + 1;
    end
    return map;
  endfunction

  localparam logic [CH_CODES-1:0][IdxW-1:0] ChanMap = build_chan_map();

  // Configuration registers
  logic [RECIP_W-1:0]        recip_q;
  logic signed [SHIFT_W-1:0] shift_q;
  logic                      mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q <= RECIP_RESET;
      shift_q <= '0;
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAreaRecip: recip_q <= cfg_wdata_i[RECIP_W-1:0];
        CfgExpShift:  shift_q <= $signed(cfg_wdata_i[SHIFT_W-1:0]);
        CfgOutMode:   mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic            clr_busy_q;
  logic [IdxW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + IdxW'(1);
      if (clr_cnt_q == LastIdx) clr_busy_q <= 1'b0;
    end
  end

  // Pipeline control
  logic     s1_valid_q;
  qap_in_t  s1_item_q;
  logic [IdxW-1:0] s1_idx_q;
  logic     s2_valid_q;
  qap_sum_t s2_sum_q;
  logic     scl_ready;
  logic     s2_ready;
  logic     s1_adv;
  logic     s1_go;
  logic     s1_ready;
  logic     in_accept;

  assign s2_ready   = !s2_valid_q || scl_ready;
  assign s1_adv     = !s1_item_q.last_position || s2_ready;
  assign s1_go      = s1_valid_q && s1_adv;
  assign s1_ready   = !s1_valid_q || s1_adv;
  assign in_stall_o = clr_busy_q || !s1_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Sum memory: read on accept, write back when the item leaves stage 1
  logic [SUM_W-1:0] sum_mem [CHANNELS];
  logic [SUM_W-1:0] rd_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic [IdxW-1:0]  mem_raddr;
  logic [SUM_W-1:0] wb_data;

  assign mem_raddr = ChanMap[in_item_i.channel];
  assign mem_we    = clr_busy_q || s1_go;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : s1_idx_q;
  assign mem_wdata = clr_busy_q ? '0 : wb_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) sum_mem[mem_waddr] <= mem_wdata;
    if (in_accept) rd_q <= sum_mem[mem_raddr];
  end

  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
      s1_idx_q  <= mem_raddr;
    end
  end

  // Forward the last written sum to an item that read before it landed
  logic             fwd_valid_q;
  logic [IdxW-1:0]  fwd_idx_q;
  logic [SUM_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_go) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= wb_data;
    end
  end

  // Accumulate with saturation; clear the entry on the last position
  logic [SUM_W-1:0] operand;
  logic [SUM_W:0]   acc_wide;
  logic [SUM_W-1:0] acc_sat;

  always_comb begin
    operand  = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_data_q : rd_q;
    acc_wide = {operand[SUM_W-1], operand}
             + {{(SUM_W+1-SAMPLE_W){s1_item_q.sample[SAMPLE_W-1]}}, s1_item_q.sample};
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
      acc_sat = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sat = acc_wide[SUM_W-1:0];
    end
    wb_data = s1_item_q.last_position ? '0 : acc_sat;
  end

  // Stage 2: hold the finished window sum for the scaler
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && s1_item_q.last_position;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q && s1_item_q.last_position) begin
      s2_sum_q.sum           <= $signed(acc_sat);
      s2_sum_q.channel       <= s1_item_q.channel;
      s2_sum_q.last_of_pixel <= s1_item_q.last_channel;
    end
  end

  // Scale, round and saturate
  qap_scale_cfg_t scale_cfg;

  assign scale_cfg.area_reciprocal = recip_q;
  assign scale_cfg.exponent_shift  = shift_q;
  assign scale_cfg.output_mode     = mode_q;

  qap_scaler u_scaler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_cfg),
    .sum_valid_i (s2_valid_q),
    .sum_ready_o (scl_ready),
    .sum_i       (s2_sum_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // No item sits in the accumulate stage during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_valid_q)
    else $error("item in accumulate stage during clearing pass");

  // A completed window always reaches the scaler hand-off stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_item_q.last_position |=> s2_valid_q)
    else $error("window result dropped after accumulation");

  // A held accumulate stage keeps its entry and does not write back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_idx_q))
    else $error("stalled accumulate stage lost its item");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/qap_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized average pooling scaler
// Four-stage pipeline: magnitude, reciprocal multiply, rounding shift,
// round and saturate into the output register.
// ----------------------------------------------------------------------------
module qap_scaler import qap_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire qap_scale_cfg_t cfg_i,
  input  wire logic           sum_valid_i,
  output logic                sum_ready_o,
  input  wire qap_sum_t       sum_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output qap_out_t            out_item_o
);

  // Stage valids and ready chain
  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic a_ready, b_ready, c_ready, d_ready;

  assign d_ready     = !out_valid_q || !out_stall_i;
  assign c_ready     = !c_valid_q || d_ready;
  assign b_ready     = !b_valid_q || c_ready;
  assign a_ready     = !a_valid_q || b_ready;
  assign sum_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q   <= sum_valid_i;
      if (b_ready) b_valid_q   <= a_valid_q;
      if (c_ready) c_valid_q   <= b_valid_q;
      if (d_ready) out_valid_q <= c_valid_q;
    end
  end

  // Stage A: split the sum into sign and magnitude
  logic [SUM_W-1:0] a_mag_q;
  qap_meta_t        a_meta_q;

  always_ff @(posedge clk_i) begin
    if (a_ready && sum_valid_i) begin
      a_mag_q          <= sum_i.sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum_i.sum))
                                              : SUM_W'(sum_i.sum);
      a_meta_q.neg     <= sum_i.sum[SUM_W-1];
      a_meta_q.channel <= sum_i.channel;
      a_meta_q.last_of_pixel <= sum_i.last_of_pixel;
    end
  end

  // Stage B: multiply by the area reciprocal
  logic [MAG_W-1:0] prod;
  logic [MAG_W-1:0] b_mag_q;
  qap_meta_t        b_meta_q;

  assign prod = {{(MAG_W-SUM_W){1'b0}}, a_mag_q}
              * {{(MAG_W-RECIP_W){1'b0}}, cfg_i.area_reciprocal};

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_mag_q  <= prod;
      b_meta_q <= a_meta_q;
    end
  end

  // Stage C: shift by the exponent distance, find the rounding decision
  logic signed [SHIFT_W:0] rdist;
  logic [SHIFT_W-1:0]      rsh;
  logic [3:0]              lsh;
  logic [MAG_W-1:0]        shifted;
  logic [MAG_W-1:0]        sticky_mask;
  logic [MAG_W-1:0]        clamped;
  logic [MAG_W-1:0]        c_mag_d;
  logic                    c_round_d;
  logic [MAG_W-1:0]        c_mag_q;
  logic                    c_round_q;
  qap_meta_t               c_meta_q;

  assign rdist = (SHIFT_W+1)'(16) - $signed({cfg_i.exponent_shift[SHIFT_W-1],
                                              cfg_i.exponent_shift});

  always_comb begin
    rsh         = SHIFT_W'(rdist - (SHIFT_W+1)'(1));
    lsh         = 4'((SHIFT_W+1)'(0) - rdist);
    shifted     = b_mag_q >> rsh;
    sticky_mask = (MAG_W'(1) << rsh) - MAG_W'(1);
    clamped     = (b_mag_q > MAG_CLAMP) ? MAG_CLAMP : b_mag_q;
    priority if (rdist > 0) begin
      // Right shift, round half to even on the magnitude
      c_mag_d   = {1'b0, shifted[MAG_W-1:1]};
      c_round_d = shifted[0] && ((|(b_mag_q & sticky_mask)) || shifted[1]);
    end else if (rdist == 0) begin
      c_mag_d   = b_mag_q;
      c_round_d = 1'b0;
    end else begin
      // Left shift of the clamped magnitude, saturates the same way
      c_mag_d   = clamped << lsh;
      c_round_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_mag_q   <= c_mag_d;
      c_round_q <= c_round_d;
      c_meta_q  <= b_meta_q;
    end
  end

  // Stage D: apply rounding, saturate to the output width, hold for the receiver
  logic [MAG_W-1:0] mag_r;
  logic [MAG_W-1:0] lim_pos;
  logic [OUT_W-1:0] val_d;
  qap_out_t         out_item_q;

  always_comb begin
    mag_r   = c_mag_q + MAG_W'(c_round_q);
    lim_pos = cfg_i.output_mode ? OUT16_MAX : OUT8_MAX;
    if (!c_meta_q.neg) begin
      val_d = (mag_r > lim_pos) ? lim_pos[OUT_W-1:0] : mag_r[OUT_W-1:0];
    end else begin
      val_d = (mag_r > lim_pos + MAG_W'(1))
            ? (OUT_W'(0) - (lim_pos[OUT_W-1:0] + OUT_W'(1)))
            : (OUT_W'(0) - mag_r[OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && c_valid_q) begin
      out_item_q.pooled_value  <= $signed(val_d);
      out_item_q.out_channel   <= c_meta_q.channel;
      out_item_q.last_of_pixel <= c_meta_q.last_of_pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // 8-bit mode never emits a value outside the signed 8-bit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !cfg_i.output_mode |->
      (out_item_q.pooled_value <= 16'sd127) && (out_item_q.pooled_value >= -16'sd128))
    else $error("pooled value outside 8-bit range");

  // No rounding increment unless bits were shifted out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && (rdist <= 0) |-> !c_round_q)
    else $error("rounding requested without a right shift");

  // A taken sum enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid_i && sum_ready_o |=> a_valid_q)
    else $error("accepted sum lost in scaler");
`endif

endmodule
`default_nettype wire
